FILE: hw/rtl/ksolv_pkg.sv
// ksolv_pkg: shared types and constants for the Kaczmarz solver.
// Holds the controller/datapath command and status structs and config codes.
// No dependencies.
package ksolv_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd1;

	localparam logic [4:0]  SYS_SIZE_RST = 5'd16;
	localparam logic [15:0] ITER_RST     = 16'd1;

	typedef struct packed {
		logic load_en;
		logic j_clr;
		logic j_inc;
		logic row_clr;
		logic row_inc;
		logic iter_load;
		logic iter_dec;
		logic acc_clr;
		logic mul_en;
		logic acc_en;
		logic res_en;
		logic flag_clr;
		logic flag_set;
		logic x_clr_wr;
		logic upd_mul_en;
		logic div_start;
		logic x_upd_wr;
		logic out_load;
	} ksolv_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic load_last;
		logic j_last;
		logic iter_zero;
		logic power_zero;
		logic div_busy;
		logic out_taken;
	} ksolv_sts_t;

endpackage

FILE: hw/rtl/ksolv_ram.sv
// ksolv_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module ksolv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/ksolv_div.sv
// ksolv_div: bit-serial divider, min(floor(num * 2^16 / den), 2^32).
// One quotient bit per cycle. No dependencies.
module ksolv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic [32:0] quo
);

	localparam logic [32:0] QCAP = 33'h1_0000_0000;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [32:0] nsh_q;
	logic [32:0] quo_q;
	logic        sat_q;
	logic [64:0] trial;
	logic        ge;

	assign trial = {rem_q, nsh_q[32]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd33;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= {17'd0, num[63:17]} >= den;
			rem_q <= {17'd0, num[63:17]};
			nsh_q <= {num[16:0], 16'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(trial - {1'b0, den}) : trial[63:0];
			nsh_q <= {nsh_q[31:0], 1'b0};
			quo_q <= {quo_q[31:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = (sat_q || quo_q > QCAP) ? QCAP : quo_q;

endmodule

FILE: hw/rtl/ksolv_dpath.sv
// ksolv_dpath: stores, counters, multipliers, accumulators and output register.
// Depends on ksolv_pkg, ksolv_ram and ksolv_div.
module ksolv_dpath #(
	parameter int MAX_SIZE = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ksolv_pkg::ksolv_cmd_t               cmd,
	output ksolv_pkg::ksolv_sts_t               sts,
	input  logic                                in_valid,
	input  logic signed [31:0]                  load_value,
	input  logic                                cfg_valid,
	input  logic [ksolv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ksolv_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  solution_value,
	output logic [3:0]                          element_index,
	output logic                                last_element,
	output logic                                zero_row_seen
);

	localparam int IW  = $clog2(MAX_SIZE);
	localparam int CW  = $clog2(MAX_SIZE + 1);
	localparam int MD  = MAX_SIZE * MAX_SIZE;
	localparam int AW  = $clog2(MD);

	logic [4:0]  sys_q;
	logic [15:0] iter_cfg_q;
	logic [CW-1:0] n;
	logic [CW-1:0] n_m1;

	logic          rhs_phase_q;
	logic [CW-1:0] lrow_q;
	logic [CW-1:0] lcol_q;
	logic [AW-1:0] lbase_q;
	logic          in_acc;
	logic          pos_rst;

	logic [CW-1:0] j_q;
	logic [CW-1:0] row_q;
	logic [AW-1:0] sbase_q;
	logic [15:0]   iter_q;

	logic [31:0] mat_rdata;
	logic [31:0] rhs_rdata;
	logic [31:0] x_rdata;
	logic signed [31:0] mat_rd;
	logic signed [31:0] rhs_rd;
	logic signed [31:0] x_rd;

	logic signed [63:0] pdot_s1;
	logic signed [63:0] ppow_s1;
	logic signed [63:0] dot_q;
	logic signed [63:0] pow_q;
	logic signed [31:0] res_q;
	logic               flag_q;
	logic signed [64:0] diff;
	logic [31:0]        rmag;
	logic [31:0]        amag;
	logic [63:0]        prod_q;
	logic               aneg_q;
	logic signed [31:0] xold_q;
	logic [32:0]        step;
	logic signed [34:0] sstep;
	logic signed [34:0] xsum;
	logic signed [31:0] xnew;
	logic               div_busy;

	logic               ovalid_q;
	logic signed [31:0] sol_q;
	logic [3:0]         idx_q;
	logic               last_q;
	logic               zr_q;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
	                                                 input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	always_comb begin
		if (sys_q == '0) begin
			n = CW'(1);
		end else if (int'(sys_q) > MAX_SIZE) begin
			n = CW'(MAX_SIZE);
		end else begin
			n = CW'(sys_q);
		end
	end
	assign n_m1 = n - CW'(1);

	assign in_acc  = in_valid && cmd.load_en;
	assign pos_rst = (in_acc && rhs_phase_q && lrow_q == n_m1) ||
	                 (cfg_valid && cfg_index == ksolv_pkg::CFG_SYSTEM_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q      <= ksolv_pkg::SYS_SIZE_RST;
			iter_cfg_q <= ksolv_pkg::ITER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ksolv_pkg::CFG_SYSTEM_SIZE:     sys_q      <= cfg_data[4:0];
				ksolv_pkg::CFG_ITERATION_COUNT: iter_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhs_phase_q <= 1'b0;
			lrow_q      <= '0;
			lcol_q      <= '0;
			lbase_q     <= '0;
		end else if (pos_rst) begin
			rhs_phase_q <= 1'b0;
			lrow_q      <= '0;
			lcol_q      <= '0;
			lbase_q     <= '0;
		end else if (in_acc) begin
			if (rhs_phase_q) begin
				lrow_q <= lrow_q + CW'(1);
			end else if (lcol_q == n_m1) begin
				lcol_q <= '0;
				if (lrow_q == n_m1) begin
					rhs_phase_q <= 1'b1;
					lrow_q      <= '0;
				end else begin
					lrow_q  <= lrow_q + CW'(1);
					lbase_q <= lbase_q + AW'(MAX_SIZE);
				end
			end else begin
				lcol_q <= lcol_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			row_q   <= '0;
			sbase_q <= '0;
			iter_q  <= '0;
			flag_q  <= 1'b0;
		end else begin
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.row_clr || (cmd.row_inc && row_q == n_m1)) begin
				row_q   <= '0;
				sbase_q <= '0;
			end else if (cmd.row_inc) begin
				row_q   <= row_q + CW'(1);
				sbase_q <= sbase_q + AW'(MAX_SIZE);
			end
			if (cmd.iter_load) begin
				iter_q <= iter_cfg_q;
			end else if (cmd.iter_dec) begin
				iter_q <= iter_q - 16'd1;
			end
			if (cmd.flag_clr) begin
				flag_q <= 1'b0;
			end else if (cmd.flag_set) begin
				flag_q <= 1'b1;
			end
		end
	end

	ksolv_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
		.clk   (clk),
		.we    (in_acc && !rhs_phase_q),
		.waddr (lbase_q + AW'(lcol_q)),
		.wdata (load_value),
		.raddr (sbase_q + AW'(j_q)),
		.rdata (mat_rdata)
	);

	ksolv_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
		.clk   (clk),
		.we    (in_acc && rhs_phase_q),
		.waddr (lrow_q[IW-1:0]),
		.wdata (load_value),
		.raddr (row_q[IW-1:0]),
		.rdata (rhs_rdata)
	);

	ksolv_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x (
		.clk   (clk),
		.we    (cmd.x_clr_wr || cmd.x_upd_wr),
		.waddr (j_q[IW-1:0]),
		.wdata (cmd.x_clr_wr ? 32'd0 : xnew),
		.raddr (j_q[IW-1:0]),
		.rdata (x_rdata)
	);

	assign mat_rd = mat_rdata;
	assign rhs_rd = rhs_rdata;
	assign x_rd   = x_rdata;

	assign diff = 65'(rhs_rd) - 65'(dot_q >>> 16);
	assign rmag = res_q[31] ? ~res_q + 32'd1 : res_q;
	assign amag = mat_rd[31] ? ~mat_rd + 32'd1 : mat_rd;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			pdot_s1 <= mat_rd * x_rd;
			ppow_s1 <= mat_rd * mat_rd;
		end
		if (cmd.acc_clr) begin
			dot_q <= '0;
			pow_q <= '0;
		end else if (cmd.acc_en) begin
			dot_q <= sat_add64(dot_q, pdot_s1);
			pow_q <= sat_add64(pow_q, ppow_s1);
		end
		if (cmd.res_en) begin
			if ((diff[64:31] == '0) || (diff[64:31] == '1)) begin
				res_q <= diff[31:0];
			end else begin
				res_q <= diff[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
		end
		if (cmd.upd_mul_en) begin
			prod_q <= 64'(rmag) * 64'(amag);
			aneg_q <= res_q[31] ^ mat_rd[31];
			xold_q <= x_rd;
		end
	end

	ksolv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q),
		.den    (pow_q),
		.busy   (div_busy),
		.quo    (step)
	);

	assign sstep = aneg_q ? -$signed({2'b00, step}) : $signed({2'b00, step});
	assign xsum  = 35'(xold_q) + sstep;
	assign xnew  = ((xsum[34:31] == '0) || (xsum[34:31] == '1)) ? xsum[31:0] :
	               (xsum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (ovalid_q && !out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sol_q  <= x_rd;
			idx_q  <= 4'(j_q);
			last_q <= (j_q == n_m1);
			zr_q   <= flag_q;
		end
	end

	assign out_valid      = ovalid_q;
	assign solution_value = sol_q;
	assign element_index  = idx_q;
	assign last_element   = last_q;
	assign zero_row_seen  = zr_q;

	assign sts.in_fire    = in_acc;
	assign sts.load_last  = rhs_phase_q && (lrow_q == n_m1);
	assign sts.j_last     = (j_q == n_m1);
	assign sts.iter_zero  = (iter_q == '0);
	assign sts.power_zero = (pow_q == '0);
	assign sts.div_busy   = div_busy;
	assign sts.out_taken  = ovalid_q && !out_stall;

endmodule

FILE: hw/rtl/ksolv_ctrl.sv
// ksolv_ctrl: sequencer for loading, solving and result delivery.
// Depends on ksolv_pkg.
module ksolv_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ksolv_pkg::ksolv_sts_t sts,
	output ksolv_pkg::ksolv_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD, S_CLR, S_ITER, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_RES,
		S_UPD_RD, S_UPD_MUL, S_DIV_START, S_DIV, S_UPD_WR, S_NEXT,
		S_OUT_RD, S_OUT_LD, S_OUT_WAIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD:      if (sts.in_fire && sts.load_last) state_q <= S_CLR;
				S_CLR:       if (sts.j_last) state_q <= S_ITER;
				S_ITER:      state_q <= sts.iter_zero ? S_OUT_RD : S_DOT_RD;
				S_DOT_RD:    state_q <= S_DOT_MUL;
				S_DOT_MUL:   state_q <= S_DOT_ACC;
				S_DOT_ACC:   state_q <= sts.j_last ? S_RES : S_DOT_RD;
				S_RES:       state_q <= sts.power_zero ? S_NEXT : S_UPD_RD;
				S_UPD_RD:    state_q <= S_UPD_MUL;
				S_UPD_MUL:   state_q <= S_DIV_START;
				S_DIV_START: state_q <= S_DIV;
				S_DIV:       if (!sts.div_busy) state_q <= S_UPD_WR;
				S_UPD_WR:    state_q <= sts.j_last ? S_NEXT : S_UPD_RD;
				S_NEXT:      state_q <= S_ITER;
				S_OUT_RD:    state_q <= S_OUT_LD;
				S_OUT_LD:    state_q <= S_OUT_WAIT;
				S_OUT_WAIT:  if (sts.out_taken) state_q <= sts.j_last ? S_LOAD : S_OUT_RD;
				default:     state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LOAD: begin
				cmd.load_en = 1'b1;
				if (sts.in_fire && sts.load_last) begin
					cmd.j_clr    = 1'b1;
					cmd.flag_clr = 1'b1;
				end
			end
			S_CLR: begin
				cmd.x_clr_wr = 1'b1;
				if (sts.j_last) begin
					cmd.row_clr   = 1'b1;
					cmd.iter_load = 1'b1;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			S_ITER: begin
				cmd.j_clr   = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			S_DOT_MUL: cmd.mul_en = 1'b1;
			S_DOT_ACC: begin
				cmd.acc_en = 1'b1;
				cmd.j_inc  = !sts.j_last;
			end
			S_RES: begin
				cmd.flag_set = sts.power_zero;
				cmd.res_en   = 1'b1;
				cmd.j_clr    = 1'b1;
			end
			S_UPD_MUL:   cmd.upd_mul_en = 1'b1;
			S_DIV_START: cmd.div_start  = 1'b1;
			S_UPD_WR: begin
				cmd.x_upd_wr = 1'b1;
				cmd.j_inc    = !sts.j_last;
			end
			S_NEXT: begin
				cmd.row_inc  = 1'b1;
				cmd.iter_dec = 1'b1;
			end
			S_OUT_LD: cmd.out_load = 1'b1;
			S_OUT_WAIT: cmd.j_inc = sts.out_taken && !sts.j_last;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/kaczmarz_linear_solver_unit.sv
// Kaczmarz linear solver top level: loads A and b, runs cyclic row
// projections in Q16.16 and streams out the solution. Matrix, rhs and
// solution live in RAMs; a sequencer steps a dot-product multiplier pair,
// an update multiplier and one bit-serial divider. Loading takes one value
// per cycle. The value that completes b starts the solve, during which
// input is stalled: x is first cleared, then each projection forms the dot
// product and norm of a row and updates x element by element through the
// divider; a row with zero norm skips the update. Results then leave one
// at a time, the next read only after the last one is taken.
// Depends on ksolv_pkg, ksolv_ctrl, ksolv_dpath.
module kaczmarz_linear_solver_unit #(
	parameter int MAX_SIZE = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [31:0]               load_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               solution_value,
	output logic [3:0]                       element_index,
	output logic                             last_element,
	output logic                             zero_row_seen,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ksolv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ksolv_pkg::CFG_DATA_W-1:0] cfg_data
);

	ksolv_pkg::ksolv_cmd_t cmd;
	ksolv_pkg::ksolv_sts_t sts;

	assign in_stall  = !cmd.load_en;
	assign cfg_ready = 1'b1;

	ksolv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ksolv_dpath #(.MAX_SIZE(MAX_SIZE)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_valid       (in_valid),
		.load_value     (load_value),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.solution_value (solution_value),
		.element_index  (element_index),
		.last_element   (last_element),
		.zero_row_seen  (zero_row_seen)
	);

endmodule
